FILE: hw/rtl/ascon_pkg.sv
package ascon_pkg;

   localparam int StateWords = 5;
   localparam int TagBits    = 128;
   localparam int MaxRounds  = 12;

   localparam logic [1:0] ModeStart = 2'd0;
   localparam logic [1:0] ModeAd    = 2'd1;
   localparam logic [1:0] ModePt    = 2'd2;

   localparam logic [2:0] CsrKeyHigh = 3'd0;
   localparam logic [2:0] CsrKeyLow  = 3'd1;
   localparam logic [2:0] CsrRoundsA = 3'd2;
   localparam logic [2:0] CsrRoundsB = 3'd3;
   localparam logic [2:0] CsrRate    = 3'd4;

   localparam logic [1:0] PhaseIdle    = 2'd0;
   localparam logic [1:0] PhaseStarted = 2'd1;
   localparam logic [1:0] PhaseAd      = 2'd2;
   localparam logic [1:0] PhasePt      = 2'd3;

   // datapath load operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,        // load iv, key, nonce
      OP_KEY_TAIL,    // xor key into words 3,4
      OP_ABSORB,      // xor padded block into rate
      OP_PAD_FULL,    // xor pad bit into word 0 msb
      OP_DOMAIN,      // xor 1 into word 4
      OP_PT_ABSORB,   // absorb plaintext and capture ciphertext
      OP_KEY_FINAL    // xor key before finalization
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       round_en;
      logic [3:0] round_idx;
   } dp_cmd_type;

   function automatic logic [3:0] clamp_rounds(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (v == 4'd0) r = 4'd1;
      else if (v > 4'd12) r = 4'd12;
      return r;
   endfunction

   function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [319:0] ascon_round(input logic [319:0] s,
                                                input logic [3:0] j);
      logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
      x0 = s[319:256]; x1 = s[255:192]; x2 = s[191:128];
      x3 = s[127:64];  x4 = s[63:0];
      x2 = x2 ^ {56'd0, 4'd15 - j, j};
      x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
      t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3;
      t3 = ~x3 & x4; t4 = ~x4 & x0;
      x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
      x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
      x0 = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
      x1 = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
      x2 = x2 ^ ror64(x2, 1) ^ ror64(x2, 6);
      x3 = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
      x4 = x4 ^ ror64(x4, 7) ^ ror64(x4, 41);
      return {x0, x1, x2, x3, x4};
   endfunction

endpackage

FILE: hw/rtl/ascon_if.sv
interface ascon_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [63:0] data_high;
   logic [63:0] data_low;
   logic        is_last;
   logic [7:0]  valid_bits;
   modport source (output valid, mode, data_high, data_low, is_last, valid_bits,
                   input ready);
   modport sink (input valid, mode, data_high, data_low, is_last, valid_bits,
                 output ready);
endinterface

interface ascon_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_high;
   logic [63:0] cipher_low;
   logic [7:0]  cipher_bits;
   logic [63:0] tag_high;
   logic [63:0] tag_low;
   logic        tag_valid;
   logic        sequence_error;
   modport source (output valid, cipher_high, cipher_low, cipher_bits, tag_high,
                   tag_low, tag_valid, sequence_error, input ready);
   modport sink (input valid, cipher_high, cipher_low, cipher_bits, tag_high,
                 tag_low, tag_valid, sequence_error, output ready);
endinterface

FILE: hw/rtl/ascon_dp.sv
module ascon_dp (
   input  logic                 clock,
   input  ascon_pkg::dp_cmd_type cmd,
   input  logic [63:0]          key_high,
   input  logic [63:0]          key_low,
   input  logic                 wide,
   input  logic [3:0]           na,
   input  logic [3:0]           nb,
   input  logic [63:0]          blk_high,
   input  logic [63:0]          blk_low,
   input  logic [7:0]           vbits,
   input  logic                 full_blk,
   output logic [63:0]          c_high,
   output logic [63:0]          c_low,
   output logic [63:0]          tag_high,
   output logic [63:0]          tag_low
);
   logic [319:0] state_ff, state_in;
   logic [63:0]  c_high_ff, c_high_in, c_low_ff, c_low_in;
   logic [63:0]  mhi, mlo, phi, plo, ahi, alo;
   logic [7:0]   rate;

   always_comb begin
      rate = wide ? 8'd128 : 8'd64;
      mhi = 64'd0; mlo = 64'd0; phi = 64'd0; plo = 64'd0;
      if (full_blk || vbits >= 8'd64) mhi = '1;
      else if (vbits != 8'd0) mhi = ~64'd0 << (7'd64 - vbits[6:0]);
      if (full_blk || vbits >= 8'd128) mlo = '1;
      else if (vbits > 8'd64) mlo = ~64'd0 << (8'd128 - vbits);
      if (!full_blk) begin
         if (vbits < 8'd64) phi = 64'd1 << (6'd63 - vbits[5:0]);
         else if (vbits < 8'd128) plo = 64'd1 << (7'd127 - vbits[6:0]);
      end
      ahi = (blk_high & mhi) | phi;
      alo = wide ? ((blk_low & mlo) | plo) : 64'd0;
      state_in = state_ff;
      c_high_in = c_high_ff;
      c_low_in = c_low_ff;
      case (cmd.op)
         ascon_pkg::OP_INIT:
            state_in = {8'h80, rate, 4'd0, na, 4'd0, nb, 32'd0,
                        key_high, key_low, blk_high, blk_low};
         ascon_pkg::OP_KEY_TAIL:
            state_in[127:0] = state_ff[127:0] ^ {key_high, key_low};
         ascon_pkg::OP_ABSORB: begin
            state_in[319:256] = state_ff[319:256] ^ ahi;
            state_in[255:192] = state_ff[255:192] ^ alo;
         end
         ascon_pkg::OP_PAD_FULL: state_in[319] = ~state_ff[319];
         ascon_pkg::OP_DOMAIN: state_in[0] = ~state_ff[0];
         ascon_pkg::OP_PT_ABSORB: begin
            state_in[319:256] = state_ff[319:256] ^ ahi;
            state_in[255:192] = state_ff[255:192] ^ alo;
            c_high_in = state_in[319:256] & mhi;
            c_low_in = wide ? (state_in[255:192] & mlo) : 64'd0;
         end
         ascon_pkg::OP_KEY_FINAL:
            if (wide) state_in[191:64] = state_ff[191:64] ^ {key_high, key_low};
            else state_in[255:128] = state_ff[255:128] ^ {key_high, key_low};
         default: ;
      endcase
      if (cmd.round_en) state_in = ascon_pkg::ascon_round(state_in, cmd.round_idx);
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      c_high_ff <= c_high_in;
      c_low_ff <= c_low_in;
   end

   assign c_high = c_high_ff;
   assign c_low = c_low_ff;
   assign tag_high = state_ff[127:64] ^ key_high;
   assign tag_low = state_ff[63:0] ^ key_low;
endmodule

FILE: hw/rtl/ascon_ctrl.sv
module ascon_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            mode,
   input  logic                  is_last,
   input  logic                  empty_blk,
   input  logic                  full_blk,
   input  logic [3:0]            na,
   input  logic [3:0]            nb,
   output ascon_pkg::dp_cmd_type cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  out_cipher,
   output logic                  out_tag,
   output logic                  out_err
);
   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_ADP1, S_ADPAD, S_ADP2, S_PTP, S_PTPAD, S_FIN, S_RESP
   } st_type;

   st_type      st_ff;
   logic [1:0]  phase_ff;
   logic [3:0]  cnt_ff;
   logic        last_ff, full_ff, cipher_ff, tag_ff, err_ff, rv_ff;

   logic take;
   assign req_ready = (st_ff == S_IDLE) && !rv_ff;
   assign take = req_valid && req_ready;
   assign rsp_valid = rv_ff;
   assign out_cipher = cipher_ff;
   assign out_tag = tag_ff;
   assign out_err = err_ff;

   always_comb begin
      cmd = '{op: ascon_pkg::OP_NONE, round_en: 1'b0, round_idx: 4'd0};
      case (st_ff)
         S_IDLE: if (take) begin
            case (mode)
               ascon_pkg::ModeStart: cmd.op = ascon_pkg::OP_INIT;
               ascon_pkg::ModeAd:
                  if ((phase_ff == ascon_pkg::PhaseStarted ||
                       phase_ff == ascon_pkg::PhaseAd) &&
                      !(is_last && empty_blk && phase_ff == ascon_pkg::PhaseStarted))
                     cmd.op = ascon_pkg::OP_ABSORB;
                  else if (phase_ff == ascon_pkg::PhaseStarted ||
                           phase_ff == ascon_pkg::PhaseAd)
                     cmd.op = ascon_pkg::OP_DOMAIN;
               ascon_pkg::ModePt:
                  if (phase_ff == ascon_pkg::PhaseStarted)
                     cmd.op = ascon_pkg::OP_DOMAIN;
                  else if (phase_ff == ascon_pkg::PhasePt)
                     cmd.op = ascon_pkg::OP_PT_ABSORB;
               default: ;
            endcase
         end
         S_INIT, S_ADP1, S_ADP2, S_PTP, S_FIN: begin
            cmd.round_en = 1'b1;
            cmd.round_idx = 4'd12 - ((st_ff == S_INIT || st_ff == S_FIN) ? na : nb)
                            + cnt_ff;
            if (st_ff == S_FIN && cnt_ff == 4'd0) cmd.op = ascon_pkg::OP_KEY_FINAL;
         end
         S_ADPAD: cmd.op = ascon_pkg::OP_PAD_FULL;
         S_PTPAD: cmd.op = ascon_pkg::OP_PT_ABSORB;
         S_RESP: cmd.op = (phase_ff == ascon_pkg::PhasePt) ? ascon_pkg::OP_DOMAIN
                                                           : ascon_pkg::OP_KEY_TAIL;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         phase_ff <= ascon_pkg::PhaseIdle;
         cnt_ff <= 4'd0;
         rv_ff <= 1'b0;
         last_ff <= 1'b0; full_ff <= 1'b0;
         cipher_ff <= 1'b0; tag_ff <= 1'b0; err_ff <= 1'b0;
      end else begin
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (take) begin
               cnt_ff <= 4'd0;
               last_ff <= is_last;
               full_ff <= full_blk;
               cipher_ff <= 1'b0; tag_ff <= 1'b0; err_ff <= 1'b0;
               case (mode)
                  ascon_pkg::ModeStart: begin
                     st_ff <= S_INIT;
                     phase_ff <= ascon_pkg::PhaseStarted;
                  end
                  ascon_pkg::ModeAd:
                     if (phase_ff == ascon_pkg::PhaseStarted ||
                         phase_ff == ascon_pkg::PhaseAd) begin
                        if (is_last && empty_blk &&
                            phase_ff == ascon_pkg::PhaseStarted) begin
                           rv_ff <= 1'b1;
                        end else st_ff <= S_ADP1;
                        phase_ff <= is_last ? ascon_pkg::PhasePt : ascon_pkg::PhaseAd;
                     end else begin
                        err_ff <= 1'b1; rv_ff <= 1'b1;
                     end
                  ascon_pkg::ModePt:
                     if (phase_ff == ascon_pkg::PhaseStarted) begin
                        st_ff <= S_PTPAD;
                        phase_ff <= ascon_pkg::PhasePt;
                     end else if (phase_ff == ascon_pkg::PhasePt) begin
                        cipher_ff <= 1'b1;
                        if (!is_last || full_blk) st_ff <= S_PTP;
                        else begin
                           tag_ff <= 1'b1;
                           st_ff <= S_FIN;
                        end
                     end else begin
                        err_ff <= 1'b1; rv_ff <= 1'b1;
                     end
                  default: begin
                     err_ff <= 1'b1; rv_ff <= 1'b1;
                  end
               endcase
            end
            S_INIT, S_FIN: begin
               if (cnt_ff == na - 4'd1) begin
                  cnt_ff <= 4'd0;
                  st_ff <= (st_ff == S_INIT) ? S_RESP : S_IDLE;
                  if (st_ff == S_FIN) begin
                     rv_ff <= 1'b1;
                     phase_ff <= ascon_pkg::PhaseIdle;
                  end
               end else cnt_ff <= cnt_ff + 4'd1;
            end
            S_ADP1, S_ADP2, S_PTP: begin
               if (cnt_ff == nb - 4'd1) begin
                  cnt_ff <= 4'd0;
                  if (st_ff == S_ADP1 && last_ff && full_ff) st_ff <= S_ADPAD;
                  else if (st_ff == S_PTP && last_ff) st_ff <= S_ADPAD;
                  else if (st_ff == S_PTP) begin
                     st_ff <= S_IDLE; rv_ff <= 1'b1;
                  end else begin
                     st_ff <= last_ff ? S_RESP : S_IDLE;
                     if (!last_ff) rv_ff <= 1'b1;
                  end
               end else cnt_ff <= cnt_ff + 4'd1;
            end
            S_ADPAD: st_ff <= cipher_ff ? S_FIN : S_ADP2;
            S_PTPAD: begin
               cipher_ff <= 1'b1;
               if (!last_ff || full_ff) st_ff <= S_PTP;
               else begin
                  tag_ff <= 1'b1;
                  st_ff <= S_FIN;
               end
            end
            S_RESP: begin
               st_ff <= S_IDLE;
               if (!cipher_ff && phase_ff == ascon_pkg::PhasePt) rv_ff <= 1'b1;
            end
            default: st_ff <= S_IDLE;
         endcase
         if (st_ff == S_ADPAD && cipher_ff) tag_ff <= 1'b1;
      end
   end
endmodule

FILE: hw/rtl/ascon_aead_encrypt.sv
// Ascon-128 style authenticated encryption engine.
// req channel: mode 0 starts a message with the nonce in data_high/data_low,
// mode 1 carries one associated-data block, mode 2 one plaintext block; the
// last block of each kind has is_last set and valid_bits leading bits.
// rsp channel: one transaction per data item, carrying ciphertext, the tag
// on the final plaintext item, or sequence_error for an out-of-order or bad-mode item.
// Start items return nothing. csr port writes key, round counts and rate.
// One permutation round per cycle in the shared round unit. A start runs
// rounds_a rounds, a data block rounds_b; a full last associated-data block
// runs rounds_b twice with the pad bit between, an empty one after a start
// none; a last plaintext block ends with rounds_a finalization rounds, after
// rounds_b and the pad bit when full. The block takes one item at a time.
// Reset clears the controller and rsp state; the key and rounds return to
// their defaults. While rsp is stalled no new req is taken.
module ascon_aead_encrypt #(
   parameter int STATE_WORDS = ascon_pkg::StateWords,
   parameter int TAG_BITS    = ascon_pkg::TagBits,
   parameter int MAX_ROUNDS  = ascon_pkg::MaxRounds
) (
   input  logic        clock,
   input  logic        reset,
   ascon_req_if.sink   req,
   ascon_rsp_if.source rsp,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   logic [63:0] key_high_ff, key_low_ff;
   logic [3:0]  rounds_a_ff, rounds_b_ff, na, nb;
   logic        rate_ff;
   logic [63:0] blk_high_ff, blk_low_ff;
   logic [7:0]  vbits_ff, v_in, rate_bits;
   logic        full_in, full_ff, empty_in;
   logic [63:0] c_high, c_low, tag_high, tag_low;
   logic        o_cipher, o_tag, o_err, take;
   ascon_pkg::dp_cmd_type cmd;

   assign na = ascon_pkg::clamp_rounds(rounds_a_ff);
   assign nb = ascon_pkg::clamp_rounds(rounds_b_ff);
   assign rate_bits = rate_ff ? 8'd128 : 8'd64;
   assign v_in = (!req.is_last || req.valid_bits > rate_bits) ? rate_bits : req.valid_bits;
   assign full_in = v_in == rate_bits;
   assign empty_in = v_in == 8'd0;
   assign take = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= 64'd0; key_low_ff <= 64'd0;
         rounds_a_ff <= 4'd12; rounds_b_ff <= 4'd6; rate_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ascon_pkg::CsrKeyHigh: key_high_ff <= csr_write_data;
            ascon_pkg::CsrKeyLow:  key_low_ff <= csr_write_data;
            ascon_pkg::CsrRoundsA: rounds_a_ff <= csr_write_data[3:0];
            ascon_pkg::CsrRoundsB: rounds_b_ff <= csr_write_data[3:0];
            ascon_pkg::CsrRate:    rate_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         blk_high_ff <= req.data_high;
         blk_low_ff <= req.data_low;
         vbits_ff <= v_in;
         full_ff <= full_in;
      end
   end

   ascon_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .mode(req.mode), .is_last(req.is_last),
      .empty_blk(empty_in), .full_blk(full_in),
      .na, .nb, .cmd,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .out_cipher(o_cipher), .out_tag(o_tag), .out_err(o_err)
   );

   ascon_dp u_dp (
      .clock, .cmd,
      .key_high(key_high_ff), .key_low(key_low_ff),
      .wide(rate_ff), .na, .nb,
      .blk_high(take ? req.data_high : blk_high_ff),
      .blk_low(take ? req.data_low : blk_low_ff),
      .vbits(take ? v_in : vbits_ff), .full_blk(take ? full_in : full_ff),
      .c_high, .c_low, .tag_high, .tag_low
   );

   assign rsp.cipher_high = o_cipher ? c_high : 64'd0;
   assign rsp.cipher_low = o_cipher ? c_low : 64'd0;
   assign rsp.cipher_bits = o_cipher ? vbits_ff : 8'd0;
   assign rsp.tag_high = o_tag ? tag_high : 64'd0;
   assign rsp.tag_low = o_tag ? tag_low : 64'd0;
   assign rsp.tag_valid = o_tag;
   assign rsp.sequence_error = o_err;

`ifndef SYNTH
   a_no_take_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("req taken with rsp pending");
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.sequence_error |-> !rsp.tag_valid && rsp.cipher_bits == 8'd0)
      else $error("error rsp carries data");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.tag_high))
      else $error("rsp dropped while stalled");
`endif
endmodule

FILE: dv/ascon_aead_encrypt_tb.sv
`timescale 1ns / 1ps

module ascon_aead_encrypt_tb;

   localparam logic [1:0] ModeBad   = 2'd3;
   localparam int         Limit     = 1_000_000;
   localparam int         TotalItems = 1300;
   localparam int         Settle    = 60;

   typedef struct {
      logic [1:0]  mode;
      logic [63:0] hi;
      logic [63:0] lo;
      logic        last;
      logic [7:0]  vbits;
      bit          refused;
   } block_type;

   typedef struct {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
      logic [7:0]  cipher_bits;
      logic [63:0] tag_high;
      logic [63:0] tag_low;
      logic        tag_valid;
      logic        sequence_error;
   } cipher_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [63:0] csr_write_data;

   ascon_req_if req_ch ();
   ascon_rsp_if rsp_ch ();

   ascon_aead_encrypt dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   logic [63:0] key_hi, key_lo;
   logic [3:0]  rnd_a, rnd_b;
   logic        wide_rate;
   logic [63:0] st [5];
   logic [1:0]  msg_phase;

   cipher_type  pending_ct [$];
   int          mismatches;
   int          items_sent;
   int          cycles;
   bit          quiet;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > Limit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [3:0] eff_rounds(input logic [3:0] v);
      if (v == 4'd0) return 4'd1;
      if (v > 4'd12) return 4'd12;
      return v;
   endfunction

   function automatic logic [127:0] lead_mask(input logic [7:0] v);
      if (v == 8'd0) return '0;
      return ~128'd0 << (128 - v);
   endfunction

   function automatic logic [127:0] pad_bit(input logic [7:0] v);
      if (v < 8'd128) return 128'd1 << (127 - v);
      return '0;
   endfunction

   task automatic permute(input logic [3:0] n);
      logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
      logic [3:0]  j;
      x0 = st[0]; x1 = st[1]; x2 = st[2]; x3 = st[3]; x4 = st[4];
      for (int r = 0; r < n; r++) begin
         j = 4'(12 - n + r);
         x2 ^= {56'd0, 4'd15 - j, j};
         x0 ^= x4; x4 ^= x3; x2 ^= x1;
         t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
         x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
         x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
         x0 ^= rotr(x0, 19) ^ rotr(x0, 28);
         x1 ^= rotr(x1, 61) ^ rotr(x1, 39);
         x2 ^= rotr(x2, 1) ^ rotr(x2, 6);
         x3 ^= rotr(x3, 10) ^ rotr(x3, 17);
         x4 ^= rotr(x4, 7) ^ rotr(x4, 41);
      end
      st[0] = x0; st[1] = x1; st[2] = x2; st[3] = x3; st[4] = x4;
   endtask

   task automatic encrypt_step(input block_type b, output bit produced,
                               output cipher_type e);
      logic [3:0]   na, nb;
      logic [7:0]   rate, v;
      logic [63:0]  lo;
      logic [127:0] msk, blk, x;
      e = '{default: '0};
      produced = 1'b0;
      na = eff_rounds(rnd_a);
      nb = eff_rounds(rnd_b);
      rate = wide_rate ? 8'd128 : 8'd64;
      if (b.mode == ascon_pkg::ModeStart) begin
         st[0] = {8'd128, rate, 4'd0, na, 4'd0, nb, 32'd0};
         st[1] = key_hi; st[2] = key_lo; st[3] = b.hi; st[4] = b.lo;
         permute(na);
         st[3] ^= key_hi; st[4] ^= key_lo;
         msg_phase = ascon_pkg::PhaseStarted;
         return;
      end
      produced = 1'b1;
      lo = wide_rate ? b.lo : 64'd0;
      v = (!b.last || b.vbits > rate) ? rate : b.vbits;
      blk = {b.hi, lo};
      msk = lead_mask(v);
      x = (blk & msk) | pad_bit(v);
      if (b.mode == ascon_pkg::ModeAd && (msg_phase == ascon_pkg::PhaseStarted ||
                                          msg_phase == ascon_pkg::PhaseAd)) begin
         if (b.last && v == 8'd0 && msg_phase == ascon_pkg::PhaseStarted) begin
         end else if (b.last && v == rate) begin
            st[0] ^= b.hi; st[1] ^= lo;
            permute(nb);
            st[0][63] ^= 1'b1;
            permute(nb);
         end else if (b.last) begin
            st[0] ^= x[127:64]; st[1] ^= x[63:0];
            permute(nb);
         end else begin
            st[0] ^= b.hi; st[1] ^= lo;
            permute(nb);
         end
         if (b.last) begin
            st[4][0] ^= 1'b1;
            msg_phase = ascon_pkg::PhasePt;
         end else begin
            msg_phase = ascon_pkg::PhaseAd;
         end
      end else if (b.mode == ascon_pkg::ModePt &&
                   (msg_phase == ascon_pkg::PhaseStarted ||
                    msg_phase == ascon_pkg::PhasePt)) begin
         if (msg_phase == ascon_pkg::PhaseStarted) st[4][0] ^= 1'b1;
         msg_phase = ascon_pkg::PhasePt;
         if (!b.last || v == rate) begin
            st[0] ^= b.hi;
            e.cipher_high = st[0];
            if (wide_rate) begin
               st[1] ^= lo;
               e.cipher_low = st[1];
            end
            permute(nb);
            if (b.last) st[0][63] ^= 1'b1;
         end else begin
            st[0] ^= x[127:64];
            e.cipher_high = st[0] & msk[127:64];
            if (wide_rate) begin
               st[1] ^= x[63:0];
               e.cipher_low = st[1] & msk[63:0];
            end
         end
         e.cipher_bits = v;
         if (b.last) begin
            if (wide_rate) begin
               st[2] ^= key_hi; st[3] ^= key_lo;
            end else begin
               st[1] ^= key_hi; st[2] ^= key_lo;
            end
            permute(na);
            e.tag_high = st[3] ^ key_hi;
            e.tag_low = st[4] ^ key_lo;
            e.tag_valid = 1'b1;
            msg_phase = ascon_pkg::PhaseIdle;
         end
      end else begin
         e.sequence_error = 1'b1;
      end
   endtask

   task automatic send(input block_type b);
      int         gap;
      bit         produced;
      cipher_type e;
      gap = quiet ? 0 : $urandom_range(0, 13);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.mode = b.mode;
      req_ch.data_high = b.hi;
      req_ch.data_low = b.lo;
      req_ch.is_last = b.last;
      req_ch.valid_bits = b.vbits;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (b.refused) begin
         e = '{default: '0};
         e.sequence_error = 1'b1;
         pending_ct.push_back(e);
      end else begin
         encrypt_step(b, produced, e);
         if (produced) pending_ct.push_back(e);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_ct.size() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      case (idx)
         ascon_pkg::CsrKeyHigh: key_hi = data;
         ascon_pkg::CsrKeyLow: key_lo = data;
         ascon_pkg::CsrRoundsA: rnd_a = data[3:0];
         ascon_pkg::CsrRoundsB: rnd_b = data[3:0];
         ascon_pkg::CsrRate: wide_rate = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_key();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   function automatic logic [7:0] pick_bits();
      int rate;
      rate = wide_rate ? 128 : 64;
      case ($urandom_range(0, 6))
         0: return 8'd0;
         1: return 8'(rate);
         2: return 8'(rate - 1);
         3: return 8'($urandom_range(0, 255));
         4: return 8'($urandom_range(1, 8));
         default: return 8'($urandom_range(0, rate));
      endcase
   endfunction

   task automatic send_data(input logic [1:0] mode, input logic last);
      block_type b;
      if ($urandom_range(0, 99) < 6) begin
         b = '{2'($urandom_range(0, 3)), rand64(), rand64(), 1'($urandom),
               8'($urandom_range(0, 255)), 1'b0};
         send(b);
      end
      b = '{mode, rand64(), rand64(), last, pick_bits(), 1'b0};
      send(b);
   endtask

   task automatic send_message();
      block_type b;
      int        n_ad, n_pt;
      b = '{ascon_pkg::ModeStart, rand64(), rand64(), 1'($urandom), 8'($urandom), 1'b0};
      send(b);
      n_ad = $urandom_range(0, 3);
      if (n_ad == 0 && $urandom_range(0, 1)) begin
         b = '{ascon_pkg::ModeAd, rand64(), rand64(), 1'b1, 8'd0, 1'b0};
         send(b);
      end
      for (int i = 0; i < n_ad; i++) send_data(ascon_pkg::ModeAd, i == n_ad - 1);
      n_pt = $urandom_range(1, 3);
      for (int i = 0; i < n_pt; i++) send_data(ascon_pkg::ModePt, i == n_pt - 1);
   endtask

   always @(posedge clock) begin
      cipher_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_ct.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycles);
         end else begin
            e = pending_ct.pop_front();
            if (rsp_ch.cipher_high !== e.cipher_high || rsp_ch.cipher_low !== e.cipher_low ||
                rsp_ch.cipher_bits !== e.cipher_bits || rsp_ch.tag_high !== e.tag_high ||
                rsp_ch.tag_low !== e.tag_low || rsp_ch.tag_valid !== e.tag_valid ||
                rsp_ch.sequence_error !== e.sequence_error) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at cycle %0d", cycles);
                  $display("  expected c=%h_%h bits=%0d t=%h_%h tv=%b se=%b",
                           e.cipher_high, e.cipher_low, e.cipher_bits, e.tag_high,
                           e.tag_low, e.tag_valid, e.sequence_error);
                  $display("  actual   c=%h_%h bits=%0d t=%h_%h tv=%b se=%b",
                           rsp_ch.cipher_high, rsp_ch.cipher_low, rsp_ch.cipher_bits,
                           rsp_ch.tag_high, rsp_ch.tag_low, rsp_ch.tag_valid,
                           rsp_ch.sequence_error);
               end
            end
         end
      end
   end

   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 13);
         repeat (stall) begin
            @(negedge clock);
            rsp_ch.ready = 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   block_type plan [20] = '{
      '{ascon_pkg::ModeAd,    64'h0, 64'h0, 1'b1, 8'd64, 1'b1},
      '{ascon_pkg::ModePt,    64'h0, 64'h0, 1'b1, 8'd64, 1'b1},
      '{ModeBad,              '1, '1, 1'b1, 8'd255, 1'b1},
      '{ascon_pkg::ModeStart, '1, '1, 1'b0, 8'd0, 1'b0},
      '{ascon_pkg::ModeAd,    '1, '1, 1'b1, 8'd0, 1'b0},
      '{ascon_pkg::ModeAd,    '1, '1, 1'b1, 8'd8, 1'b1},
      '{ascon_pkg::ModePt,    '1, '1, 1'b1, 8'd64, 1'b0},
      '{ascon_pkg::ModeStart, 64'h0, 64'h0, 1'b1, 8'd128, 1'b0},
      '{ascon_pkg::ModeAd,    '1, 64'h0, 1'b0, 8'd3, 1'b0},
      '{ascon_pkg::ModeAd,    64'h0123456789abcdef, '1, 1'b1, 8'd64, 1'b0},
      '{ascon_pkg::ModePt,    64'h0, '1, 1'b0, 8'd0, 1'b0},
      '{ascon_pkg::ModePt,    '1, '1, 1'b1, 8'd0, 1'b0},
      '{ascon_pkg::ModeStart, 64'hfedcba9876543210, 64'h1, 1'b0, 8'd0, 1'b0},
      '{ascon_pkg::ModePt,    '1, '1, 1'b1, 8'd200, 1'b0},
      '{ascon_pkg::ModeStart, 64'h8000000000000000, 64'h0, 1'b0, 8'd0, 1'b0},
      '{ascon_pkg::ModeAd,    '1, '1, 1'b1, 8'd1, 1'b0},
      '{ModeBad,              64'h0, 64'h0, 1'b0, 8'd0, 1'b1},
      '{ascon_pkg::ModePt,    '1, '1, 1'b1, 8'd63, 1'b0},
      '{ascon_pkg::ModePt,    '1, '1, 1'b0, 8'd64, 1'b1},
      '{ascon_pkg::ModeAd,    '1, '1, 1'b0, 8'd64, 1'b1}
   };

   initial begin
      logic [63:0] d;
      cycles = 0;
      mismatches = 0;
      items_sent = 0;
      quiet = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = ascon_pkg::CsrKeyHigh;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.mode = ascon_pkg::ModeStart;
      req_ch.data_high = '0;
      req_ch.data_low = '0;
      req_ch.is_last = 1'b0;
      req_ch.valid_bits = '0;
      key_hi = '0; key_lo = '0; rnd_a = 4'd12; rnd_b = 4'd6; wide_rate = 1'b0;
      for (int i = 0; i < 5; i++) st[i] = '0;
      msg_phase = ascon_pkg::PhaseIdle;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) send(plan[i]);
      drain();

      for (int p = 0; items_sent < TotalItems; p++) begin
         quiet = (p % 4 == 3);
         csr_write(ascon_pkg::CsrKeyHigh, pick_key());
         csr_write(ascon_pkg::CsrKeyLow, pick_key());
         d = rand64();
         case (p % 6)
            0: d[3:0] = 4'd12;
            1: d[3:0] = 4'd1;
            2: d[3:0] = 4'd0;
            3: d[3:0] = 4'd15;
            default: d[3:0] = 4'($urandom_range(1, 12));
         endcase
         csr_write(ascon_pkg::CsrRoundsA, d);
         d = rand64();
         case (p % 5)
            0: d[3:0] = 4'd1;
            1: d[3:0] = 4'd12;
            2: d[3:0] = 4'd0;
            3: d[3:0] = 4'd14;
            default: d[3:0] = 4'($urandom_range(1, 6));
         endcase
         csr_write(ascon_pkg::CsrRoundsB, d);
         d = rand64();
         d[0] = p[0];
         csr_write(ascon_pkg::CsrRate, d);
         repeat (25) begin
            if (items_sent < TotalItems) send_message();
         end
         drain();
      end

      drain();
      if (mismatches == 0 && pending_ct.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
